FILE: rtl/rrts_pkg.sv
package rrts_pkg;

  // Sizes
  localparam int MAX_THREADS = 16;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int SLICE_W     = 15;
  localparam int ELAPSED_W   = 12;
  localparam int QUANT_W     = 17;
  localparam int REMQ_W      = 16;
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 3;

  localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(10);

  // Event codes
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_READY   = 3'd1,
    MODE_BLOCK   = 3'd2,
    MODE_UNBLOCK = 3'd3,
    MODE_EXIT    = 3'd4
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_RUNNABLE = 3'd1,
    ST_BLOCKED     = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_PRESENT     = 3'd4,
    ST_NO_CURRENT  = 3'd5
  } status_e;

  // Run queue command for one event
  typedef struct packed {
    logic             push;
    logic [IDX_W-1:0] push_id;
    logic             pop;
  } q_cmd_t;

  // Run queue response for one event
  typedef struct packed {
    logic             full;
    logic             push_ok;
    logic             pop_ok;
    logic [IDX_W-1:0] pop_id;
    logic [CNT_W-1:0] count_nxt;
  } q_stat_t;

  // Quantum store write
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [QUANT_W-1:0] data;
  } qw_t;

endpackage

FILE: rtl/rrts_run_queue.sv
module rrts_run_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrts_pkg::q_cmd_t  cmd_i,
  output rrts_pkg::q_stat_t stat_o
);

  logic [rrts_pkg::IDX_W-1:0] fifo_q [rrts_pkg::MAX_THREADS];
  logic [rrts_pkg::IDX_W-1:0] head_q, head_d;
  logic [rrts_pkg::CNT_W-1:0] count_q;
  logic [rrts_pkg::IDX_W-1:0] tail;
  logic                       empty;

  // Push at tail, then pop at head; an empty queue hands the pushed id straight through
  always_comb begin
    empty          = (count_q == '0);
    tail           = head_q + count_q[rrts_pkg::IDX_W-1:0];
    stat_o.full    = (count_q == rrts_pkg::CNT_W'(rrts_pkg::MAX_THREADS));
    stat_o.push_ok = cmd_i.push && !stat_o.full;
    stat_o.pop_ok  = cmd_i.pop && (!empty || stat_o.push_ok);
    stat_o.pop_id  = empty ? cmd_i.push_id : fifo_q[head_q];
    stat_o.count_nxt = count_q + rrts_pkg::CNT_W'(stat_o.push_ok)
                               - rrts_pkg::CNT_W'(stat_o.pop_ok);
    head_d = stat_o.pop_ok ? head_q + 1'b1 : head_q;
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= stat_o.count_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (stat_o.push_ok) begin
      fifo_q[tail] <= cmd_i.push_id;
    end
  end

endmodule

FILE: rtl/rrts_quantum_store.sv
module rrts_quantum_store (
  input  logic                         clk_i,
  input  rrts_pkg::qw_t                wr_i,
  input  logic [rrts_pkg::IDX_W-1:0]   rd_addr_i,
  output logic [rrts_pkg::QUANT_W-1:0] rd_data_o
);

  logic [rrts_pkg::QUANT_W-1:0] mem_q [rrts_pkg::MAX_THREADS];

  // Read with forwarding of a same-beat write
  always_comb begin
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_data_o = wr_i.data;
    end else begin
      rd_data_o = mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

endmodule

FILE: rtl/round_robin_thread_scheduler.sv
// Round-robin thread scheduler with time slices. Each input beat is one event
// (tick, make ready, block current, unblock id, exit current) and produces
// exactly one result beat with the running thread, a switch flag, a status
// code, the run-queue depth and the running thread's remaining quantum. An
// event is decoded and applied to the run queue, blocked set and quantum
// store in the cycle it is accepted; its result sits in the output register
// from the next cycle on. One event per clock is sustained while results are
// taken, and a new event is taken in the same cycle the held result is taken.
// The time slice register must only be written while no event is in flight.
module round_robin_thread_scheduler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rrts_pkg::SLICE_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rrts_pkg::MODE_W-1:0]         mode_i,
  input  logic [rrts_pkg::IDX_W-1:0]          thread_id_i,
  input  logic [rrts_pkg::ELAPSED_W-1:0]      elapsed_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rrts_pkg::IDX_W-1:0]          current_id_o,
  output logic                                current_valid_o,
  output logic                                switched_o,
  output logic [rrts_pkg::STATUS_W-1:0]       status_o,
  output logic [rrts_pkg::CNT_W-1:0]          ready_count_o,
  output logic signed [rrts_pkg::REMQ_W-1:0]  remaining_quantum_o
);

  localparam int QW = rrts_pkg::QUANT_W;
  localparam int RW = rrts_pkg::REMQ_W;

  logic [rrts_pkg::SLICE_W-1:0]     slice_q;
  logic                             fire;

  // Scheduler state
  logic                             run_q, run_d;
  logic [rrts_pkg::IDX_W-1:0]       rid_q, rid_d;
  logic                             exit_q, exit_d;
  logic [QW-1:0]                    cq_q, cq_d;
  logic [rrts_pkg::MAX_THREADS-1:0] blocked_q, blocked_d;
  logic [rrts_pkg::MAX_THREADS-1:0] inrq_q, inrq_d;

  // Result register
  logic                             out_valid_q;
  logic [rrts_pkg::IDX_W-1:0]       cur_id_q;
  logic                             cur_valid_q;
  logic                             sw_q;
  rrts_pkg::status_e                status_q;
  logic [rrts_pkg::CNT_W-1:0]       count_q;
  logic [RW-1:0]                    remq_q;

  // Event decode outputs
  rrts_pkg::q_cmd_t                 qcmd;
  rrts_pkg::q_stat_t                qstat;
  rrts_pkg::qw_t                    qwr;
  logic [QW-1:0]                    pick_q;
  rrts_pkg::status_e                status;
  logic                             sw;
  logic [QW-1:0]                    slice_ext;
  logic [QW:0]                      diff;
  logic [QW-1:0]                    nq;
  logic [RW-1:0]                    remq;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign slice_ext   = {{(QW - rrts_pkg::SLICE_W){1'b0}}, slice_q};

  rrts_run_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (qcmd),
    .stat_o (qstat)
  );

  rrts_quantum_store u_qstore (
    .clk_i     (clk_i),
    .wr_i      (qwr),
    .rd_addr_i (qstat.pop_id),
    .rd_data_o (pick_q)
  );

  // Event decode and state update
  always_comb begin
    run_d     = run_q;
    rid_d     = rid_q;
    exit_d    = exit_q;
    cq_d      = cq_q;
    blocked_d = blocked_q;
    inrq_d    = inrq_q;
    status    = rrts_pkg::ST_OK;
    sw        = 1'b0;
    qcmd      = '0;
    qwr       = '0;

    // charge elapsed time, saturating at the 17-bit minimum
    diff = {cq_q[QW-1], cq_q}
         - {{(QW + 1 - rrts_pkg::ELAPSED_W){1'b0}}, elapsed_ms_i};
    if (diff[QW] && !diff[QW-1]) begin
      nq = {1'b1, {(QW - 1){1'b0}}};
    end else begin
      nq = diff[QW-1:0];
    end

    case (mode_i)
      rrts_pkg::MODE_TICK: begin
        if (run_q && exit_q) begin
          // retire the exited thread
          run_d    = 1'b0;
          exit_d   = 1'b0;
          sw       = 1'b1;
          qcmd.pop = 1'b1;
        end else if (run_q) begin
          if (nq[QW-1] || (nq == '0)) begin
            // slice used up: reload, requeue, pick head
            qwr.en       = 1'b1;
            qwr.addr     = rid_q;
            qwr.data     = slice_ext;
            qcmd.push    = 1'b1;
            qcmd.push_id = rid_q;
            qcmd.pop     = 1'b1;
          end else begin
            cq_d = nq;
          end
        end else begin
          qcmd.pop = 1'b1;
        end
      end
      rrts_pkg::MODE_READY: begin
        if (inrq_q[thread_id_i] || (run_q && (rid_q == thread_id_i))) begin
          status = rrts_pkg::ST_PRESENT;
        end else if (blocked_q[thread_id_i]) begin
          status = rrts_pkg::ST_BLOCKED;
        end else if (qstat.full) begin
          status = rrts_pkg::ST_PRESENT;
        end else begin
          qwr.en       = 1'b1;
          qwr.addr     = thread_id_i;
          qwr.data     = slice_ext;
          qcmd.push    = 1'b1;
          qcmd.push_id = thread_id_i;
        end
      end
      rrts_pkg::MODE_BLOCK: begin
        if (!run_q) begin
          status = rrts_pkg::ST_NO_CURRENT;
        end else begin
          // park the thread with its remaining quantum
          blocked_d[rid_q] = 1'b1;
          qwr.en           = 1'b1;
          qwr.addr         = rid_q;
          qwr.data         = cq_q;
          run_d            = 1'b0;
          exit_d           = 1'b0;
          sw               = 1'b1;
          qcmd.pop         = 1'b1;
        end
      end
      rrts_pkg::MODE_UNBLOCK: begin
        if (!blocked_q[thread_id_i]) begin
          status = rrts_pkg::ST_NOT_FOUND;
        end else begin
          blocked_d[thread_id_i] = 1'b0;
          qcmd.push              = 1'b1;
          qcmd.push_id           = thread_id_i;
        end
      end
      rrts_pkg::MODE_EXIT: begin
        if (!run_q) begin
          status = rrts_pkg::ST_NO_CURRENT;
        end else begin
          exit_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // pick the queue head
    if (qcmd.pop) begin
      if (!qstat.pop_ok) begin
        if (run_d) begin
          sw = 1'b1;
        end
        run_d  = 1'b0;
        exit_d = 1'b0;
        status = rrts_pkg::ST_NO_RUNNABLE;
      end else begin
        cq_d = pick_q;
        if (!(run_d && (qstat.pop_id == rid_d))) begin
          sw     = 1'b1;
          rid_d  = qstat.pop_id;
          run_d  = 1'b1;
          exit_d = 1'b0;
        end
      end
    end

    // run-queue membership: set on push, then clear on pop
    if (qstat.push_ok) begin
      inrq_d[qcmd.push_id] = 1'b1;
    end
    if (qstat.pop_ok) begin
      inrq_d[qstat.pop_id] = 1'b0;
    end

    // running quantum, clamped to 16 bits
    if (!run_d) begin
      remq = '0;
    end else if (!cq_d[QW-1] && cq_d[RW-1]) begin
      remq = {1'b0, {(RW - 1){1'b1}}};
    end else if (cq_d[QW-1] && !cq_d[RW-1]) begin
      remq = {1'b1, {(RW - 1){1'b0}}};
    end else begin
      remq = cq_d[RW-1:0];
    end

    // only a taken beat reaches the queue and store
    if (!fire) begin
      qcmd = '0;
      qwr  = '0;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= rrts_pkg::SLICE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      slice_q <= cfg_data_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      rid_q       <= '0;
      exit_q      <= 1'b0;
      blocked_q   <= '0;
      inrq_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        run_q     <= run_d;
        rid_q     <= rid_d;
        exit_q    <= exit_d;
        blocked_q <= blocked_d;
        inrq_q    <= inrq_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Running quantum and result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      cq_q        <= cq_d;
      cur_id_q    <= run_d ? rid_d : '0;
      cur_valid_q <= run_d;
      sw_q        <= sw;
      status_q    <= status;
      count_q     <= qstat.count_nxt;
      remq_q      <= remq;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign current_id_o        = cur_id_q;
  assign current_valid_o     = cur_valid_q;
  assign switched_o          = sw_q;
  assign status_o            = status_q;
  assign ready_count_o       = count_q;
  assign remaining_quantum_o = remq_q;

endmodule

FILE: rtl/rrts_checker.sv
module rrts_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [rrts_pkg::IDX_W-1:0]         current_id_o,
  input logic                               current_valid_o,
  input logic                               switched_o,
  input logic [rrts_pkg::STATUS_W-1:0]      status_o,
  input logic [rrts_pkg::CNT_W-1:0]         ready_count_o,
  input logic signed [rrts_pkg::REMQ_W-1:0] remaining_quantum_o
);

  // Queue never holds more than the thread count
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ready_count_o <= rrts_pkg::CNT_W'(rrts_pkg::MAX_THREADS)))
    else $error("ready_count above thread count");

  // Idle core reports zero id and zero quantum
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !current_valid_o) |->
      ((current_id_o == '0) && (remaining_quantum_o == '0)))
    else $error("idle result carries id or quantum");

  // Failed pick leaves nothing running
  a_no_runnable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == rrts_pkg::ST_NO_RUNNABLE)) |-> !current_valid_o)
    else $error("no_runnable with a running thread");

  // Rejected events never switch threads
  a_reject_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((status_o == rrts_pkg::ST_NO_CURRENT) ||
                     (status_o == rrts_pkg::ST_NOT_FOUND) ||
                     (status_o == rrts_pkg::ST_BLOCKED) ||
                     (status_o == rrts_pkg::ST_PRESENT))) |-> !switched_o)
    else $error("rejected event switched thread");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(current_id_o) && $stable(status_o) &&
       $stable(ready_count_o) && $stable(remaining_quantum_o)))
    else $error("result beat changed while stalled");

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .current_id_o        (current_id_o),
  .current_valid_o     (current_valid_o),
  .switched_o          (switched_o),
  .status_o            (status_o),
  .ready_count_o       (ready_count_o),
  .remaining_quantum_o (remaining_quantum_o)
);

FILE: dv/round_robin_thread_scheduler_test.sv
module round_robin_thread_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One scheduler report as seen on the result port
  typedef struct {
    logic [rrts_pkg::IDX_W-1:0]         id;
    logic                               valid;
    logic                               sw;
    logic [rrts_pkg::STATUS_W-1:0]      status;
    logic [rrts_pkg::CNT_W-1:0]         count;
    logic signed [rrts_pkg::REMQ_W-1:0] quant;
  } sched_report_t;

  // Shadow scheduler: tracks run queue, blocked set and quanta, predicts reports
  class sched_tracker;
    logic [rrts_pkg::IDX_W-1:0]     slots [rrts_pkg::MAX_THREADS];
    int                             quantum [rrts_pkg::MAX_THREADS];
    int                             head;
    int                             depth;
    bit [rrts_pkg::MAX_THREADS-1:0] queued;
    bit [rrts_pkg::MAX_THREADS-1:0] blocked;
    logic [rrts_pkg::IDX_W-1:0]     cur;
    bit                             cur_valid;
    bit                             exit_mark;
    int                             slice;
    sched_report_t                  pending_reports [$];
    int                             errors;

    function new();
      head      = 0;
      depth     = 0;
      queued    = '0;
      blocked   = '0;
      cur       = '0;
      cur_valid = 0;
      exit_mark = 0;
      slice     = int'(rrts_pkg::SLICE_RESET);
      errors    = 0;
      foreach (quantum[i]) quantum[i] = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void set_slice(int value);
      slice = value;
    endfunction

    // Stored quantum is a 17-bit signed value
    function int sat17(int v);
      if (v > 65535) return 65535;
      if (v < -65536) return -65536;
      return v;
    endfunction

    function void enqueue(int id);
      if (depth >= rrts_pkg::MAX_THREADS) return;
      slots[(head + depth) % rrts_pkg::MAX_THREADS] = rrts_pkg::IDX_W'(id);
      depth++;
      queued[id] = 1'b1;
    endfunction

    // Take the queue head as running thread; same thread back is no switch
    function rrts_pkg::status_e pick_head(inout bit sw);
      int id;
      if (depth == 0) begin
        if (cur_valid) sw = 1'b1;
        cur_valid = 1'b0;
        exit_mark = 1'b0;
        return rrts_pkg::ST_NO_RUNNABLE;
      end
      id = int'(slots[head]);
      head = (head + 1) % rrts_pkg::MAX_THREADS;
      depth--;
      queued[id] = 1'b0;
      if (cur_valid && id == int'(cur)) return rrts_pkg::ST_OK;
      sw = 1'b1;
      cur = rrts_pkg::IDX_W'(id);
      cur_valid = 1'b1;
      exit_mark = 1'b0;
      return rrts_pkg::ST_OK;
    endfunction

    // Apply one accepted event and queue the report it must produce
    function void apply_event(logic [rrts_pkg::MODE_W-1:0] mode,
                              logic [rrts_pkg::IDX_W-1:0] tid,
                              logic [rrts_pkg::ELAPSED_W-1:0] elapsed);
      rrts_pkg::status_e st;
      bit                sw;
      int                q;
      sched_report_t     rep;
      st = rrts_pkg::ST_OK;
      sw = 1'b0;
      case (mode)
        rrts_pkg::MODE_TICK: begin
          if (cur_valid && exit_mark) begin
            cur_valid = 1'b0;
            exit_mark = 1'b0;
            sw = 1'b1;
            st = pick_head(sw);
          end else if (cur_valid) begin
            quantum[cur] = sat17(quantum[cur] - int'(elapsed));
            if (quantum[cur] <= 0) begin
              quantum[cur] = slice;
              enqueue(int'(cur));
              st = pick_head(sw);
            end
          end else begin
            st = pick_head(sw);
          end
        end
        rrts_pkg::MODE_READY: begin
          if (queued[tid] || (cur_valid && cur == tid)) st = rrts_pkg::ST_PRESENT;
          else if (blocked[tid]) st = rrts_pkg::ST_BLOCKED;
          else if (depth >= rrts_pkg::MAX_THREADS) st = rrts_pkg::ST_PRESENT;
          else begin
            quantum[tid] = slice;
            enqueue(int'(tid));
          end
        end
        rrts_pkg::MODE_BLOCK: begin
          if (!cur_valid) st = rrts_pkg::ST_NO_CURRENT;
          else begin
            blocked[cur] = 1'b1;
            cur_valid = 1'b0;
            exit_mark = 1'b0;
            sw = 1'b1;
            st = pick_head(sw);
          end
        end
        rrts_pkg::MODE_UNBLOCK: begin
          if (!blocked[tid]) st = rrts_pkg::ST_NOT_FOUND;
          else begin
            blocked[tid] = 1'b0;
            enqueue(int'(tid));
          end
        end
        rrts_pkg::MODE_EXIT: begin
          if (!cur_valid) st = rrts_pkg::ST_NO_CURRENT;
          else exit_mark = 1'b1;
        end
        default: ;
      endcase

      // Report is clamped to 16 bits signed
      q = cur_valid ? quantum[cur] : 0;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      rep.id     = cur_valid ? cur : '0;
      rep.valid  = cur_valid;
      rep.sw     = sw;
      rep.status = st;
      rep.count  = rrts_pkg::CNT_W'(depth);
      rep.quant  = rrts_pkg::REMQ_W'(q);
      pending_reports.push_back(rep);
    endfunction

    function void flag_field(string field, int exp_val, int act_val);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
      errors++;
    endfunction

    // Compare one result beat against the oldest predicted report
    function void check_report(sched_report_t act);
      sched_report_t exp;
      if (pending_reports.size() == 0) begin
        $display("%0t: result beat with no report pending, actual id %0d status %0d",
                 $time, act.id, act.status);
        errors++;
        return;
      end
      exp = pending_reports.pop_front();
      if (act.id !== exp.id) flag_field("current_id", exp.id, act.id);
      if (act.valid !== exp.valid) flag_field("current_valid", exp.valid, act.valid);
      if (act.sw !== exp.sw) flag_field("switched", exp.sw, act.sw);
      if (act.status !== exp.status) flag_field("status", exp.status, act.status);
      if (act.count !== exp.count) flag_field("ready_count", exp.count, act.count);
      if (act.quant !== exp.quant)
        flag_field("remaining_quantum", int'(exp.quant), int'(act.quant));
    endfunction
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [rrts_pkg::SLICE_W-1:0]       cfg_data_i = '0;
  logic                               in_valid_i = 1'b0;
  logic                               in_ready_o;
  logic [rrts_pkg::MODE_W-1:0]        mode_i = '0;
  logic [rrts_pkg::IDX_W-1:0]         thread_id_i = '0;
  logic [rrts_pkg::ELAPSED_W-1:0]     elapsed_ms_i = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic [rrts_pkg::IDX_W-1:0]         current_id_o;
  logic                               current_valid_o;
  logic                               switched_o;
  logic [rrts_pkg::STATUS_W-1:0]      status_o;
  logic [rrts_pkg::CNT_W-1:0]         ready_count_o;
  logic signed [rrts_pkg::REMQ_W-1:0] remaining_quantum_o;

  sched_tracker tracker = new();
  bit           steady = 1'b0;  // both sides run without idle cycles

  round_robin_thread_scheduler DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .mode_i              (mode_i),
    .thread_id_i         (thread_id_i),
    .elapsed_ms_i        (elapsed_ms_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .current_id_o        (current_id_o),
    .current_valid_o     (current_valid_o),
    .switched_o          (switched_o),
    .status_o            (status_o),
    .ready_count_o       (ready_count_o),
    .remaining_quantum_o (remaining_quantum_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Send one event beat; valid stays high after acceptance until the next call
  task automatic send_event(logic [rrts_pkg::MODE_W-1:0] mode,
                            logic [rrts_pkg::IDX_W-1:0] tid,
                            logic [rrts_pkg::ELAPSED_W-1:0] elapsed);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    thread_id_i  <= tid;
    elapsed_ms_i <= elapsed;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.apply_event(mode, tid, elapsed);
  endtask

  // Stop sending and wait until every report has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_slice(int value);
    cfg_data_i  <= rrts_pkg::SLICE_W'(value);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_slice(value);
  endtask

  // Mostly meaningful events: readied threads, blocks matched by unblocks,
  // ticks that often land exactly on quantum expiry
  task automatic random_event(output logic [rrts_pkg::MODE_W-1:0] mode,
                              output logic [rrts_pkg::IDX_W-1:0] tid,
                              output logic [rrts_pkg::ELAPSED_W-1:0] elapsed);
    int sel;
    int lim;
    sel     = $urandom_range(0, 99);
    tid     = rrts_pkg::IDX_W'($urandom_range(0, rrts_pkg::MAX_THREADS - 1));
    lim     = (tracker.slice < 4095) ? tracker.slice : 4095;
    case ($urandom_range(0, 5))
      0:       elapsed = '0;
      1:       elapsed = '1;
      2, 3:    elapsed = rrts_pkg::ELAPSED_W'($urandom_range(0, lim));
      default: elapsed = rrts_pkg::ELAPSED_W'($urandom_range(0, 4095));
    endcase
    if (sel < 40) begin
      mode = rrts_pkg::MODE_TICK;
      if (sel < 12 && tracker.cur_valid && tracker.quantum[tracker.cur] > 0 &&
          tracker.quantum[tracker.cur] <= 4095)
        elapsed = rrts_pkg::ELAPSED_W'(tracker.quantum[tracker.cur]);
    end else if (sel < 62) begin
      mode = rrts_pkg::MODE_READY;
    end else if (sel < 72) begin
      mode = rrts_pkg::MODE_BLOCK;
    end else if (sel < 85) begin
      mode = rrts_pkg::MODE_UNBLOCK;
      if (tracker.blocked != '0 && $urandom_range(0, 4) != 0)
        do tid = rrts_pkg::IDX_W'($urandom_range(0, rrts_pkg::MAX_THREADS - 1));
        while (!tracker.blocked[tid]);
    end else if (sel < 95) begin
      mode = rrts_pkg::MODE_EXIT;
    end else begin
      mode = rrts_pkg::MODE_W'(rrts_pkg::MODE_EXIT) + rrts_pkg::MODE_W'($urandom_range(1, 3));
    end
  endtask

  task automatic run_phase(int items);
    logic [rrts_pkg::MODE_W-1:0]    mode;
    logic [rrts_pkg::IDX_W-1:0]     tid;
    logic [rrts_pkg::ELAPSED_W-1:0] elapsed;
    int                             n;
    n = 0;
    while (n < items) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      random_event(mode, tid, elapsed);
      send_event(mode, tid, elapsed);
      if (mode <= rrts_pkg::MODE_EXIT) n++;
    end
    steady = 1'b0;
  endtask

  // Result side: random stall per beat, then check
  initial begin
    sched_report_t act;
    int            stall;
    wait (rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      act.id     = current_id_o;
      act.valid  = current_valid_o;
      act.sw     = switched_o;
      act.status = status_o;
      act.count  = ready_count_o;
      act.quant  = remaining_quantum_o;
      tracker.check_report(act);
    end
  end

  // Main sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty scheduler, duplicates, preemption, block/unblock,
    // exit retire, same thread picked back, unused modes
    send_event(rrts_pkg::MODE_TICK, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_BLOCK, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_EXIT, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_UNBLOCK, 4'd5, 12'd0);
    send_event(rrts_pkg::MODE_READY, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_READY, 4'd15, 12'd0);
    send_event(rrts_pkg::MODE_READY, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_TICK, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_READY, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_TICK, 4'd0, 12'd4095);
    send_event(rrts_pkg::MODE_BLOCK, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_READY, 4'd15, 12'd0);
    send_event(rrts_pkg::MODE_UNBLOCK, 4'd15, 12'd0);
    send_event(rrts_pkg::MODE_EXIT, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_TICK, 4'd0, 12'd1);
    send_event(rrts_pkg::MODE_TICK, 4'd0, 12'd10);
    send_event(rrts_pkg::MODE_TICK, 4'd0, 12'd3);
    send_event(rrts_pkg::MODE_BLOCK, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_UNBLOCK, 4'd15, 12'd0);
    send_event(rrts_pkg::MODE_TICK, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_W'(rrts_pkg::MODE_EXIT) + 3'd1, 4'd10, 12'hAAA);
    send_event(rrts_pkg::MODE_W'(rrts_pkg::MODE_EXIT) + 3'd2, 4'd5, 12'h555);
    send_event(rrts_pkg::MODE_W'(rrts_pkg::MODE_EXIT) + 3'd3, 4'd15, 12'hFFF);
    send_event(rrts_pkg::MODE_EXIT, 4'd0, 12'd0);
    send_event(rrts_pkg::MODE_BLOCK, 4'd0, 12'd0);
    drain();

    // Random phases over several time slices, extremes included
    write_slice(1);
    run_phase(120);
    drain();
    write_slice(32767);
    run_phase(120);
    drain();
    write_slice($urandom_range(2, 40));
    run_phase(120);
    drain();
    write_slice($urandom_range(1, 32767));
    run_phase(120);
    drain();
    write_slice(int'(rrts_pkg::SLICE_RESET));
    run_phase(120);
    drain();

    repeat (4) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
